// ----- design/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define DSSF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dssf assertion failed");

// implication checked at every clock edge outside reset
`define DSSF_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("dssf implication failed");

`else

`define DSSF_ASSERT(label, prop)
`define DSSF_ASSERT_IMP(label, cond, prop)

`endif

`endif

// ----- design/dssf_pkg.sv -----
// shared types and constants of the serial frame sender
package dssf_pkg;

	localparam logic [2:0] OP_CMD_BYTE  = 3'd0;
	localparam logic [2:0] OP_DATA_BYTE = 3'd1;
	localparam logic [2:0] OP_PIXEL     = 3'd2;
	localparam logic [2:0] OP_COL_WIN   = 3'd3;
	localparam logic [2:0] OP_ROW_WIN   = 3'd4;

	localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
	localparam logic [7:0] CMD_ROW_ADDR     = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

	localparam int MAX_FRAMES = 6;
	localparam int FRAME_BITS = 9;
	localparam int DSSF_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       is_data;
		logic [7:0] value;
	} frame_t;

	typedef struct packed {
		logic [2:0]                  frame_cnt;
		frame_t [MAX_FRAMES-1:0]     frames;
	} desc_t;

endpackage

// ----- design/display_serial_frame_sender.sv -----
// top level of the three-wire 9-bit serial frame sender
//
// Each host transaction (op plus its fields) becomes a run of serial clock
// bits for a panel interface with 9-bit frames: one command/data flag bit
// (0 command, 1 data) followed by the byte, most significant first. Op 0
// sends a command byte, op 1 a data byte, op 2 a 16-bit pixel as two data
// bytes (high first), op 3 the column-address command then start and end
// coordinates as four data bytes, op 4 the same with the row-address command
// followed by the memory-write command. Ops 5 to 7 are taken and dropped.
// Each result carries one serial bit; frame_end marks the ninth bit of a
// frame (chip select rises after it) and item_end the last bit of the
// transaction. Rate: the serializer puts out one bit per clock while pop is
// held; an item is 9 bits per frame: 9 for ops 0 and 1, 18 for a pixel, 45
// for op 3 and 54 for op 4, and back-to-back items follow without a gap
// while the queue holds the next one. The first bit of an item passes the
// front register (loaded at the accepting edge), the queue write, the
// serializer load and the output register before it shows. The front end
// decodes into a small queue of frame lists, so new transactions are taken
// while earlier ones are still being shifted.
// There is no configuration and nothing to clear after reset.
`include "assert_macros.svh"

module display_serial_frame_sender
	import dssf_pkg::*;
#(
	parameter int QUEUE_DEPTH = DSSF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// host side
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [7:0]  byte_value,
	input  logic [15:0] pixel_color,
	input  logic [15:0] coord_start,
	input  logic [15:0] coord_end,
	// serial bit side
	output logic        empty,
	input  logic        pop,
	output logic        serial_bit,
	output logic        frame_end,
	output logic        item_end
);

	// front to queue
	logic  q_push;
	desc_t q_wr_desc;
	logic  q_full;
	// queue to serializer
	logic  q_valid;
	desc_t q_rd_desc;
	logic  q_pop;

	// decode stage: one register of decoded frame lists
	dssf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.byte_value  (byte_value),
		.pixel_color (pixel_color),
		.coord_start (coord_start),
		.coord_end   (coord_end),
		.q_push      (q_push),
		.q_desc      (q_wr_desc),
		.q_full      (q_full)
	);

	// decouples decode from shifting
	dssf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_desc  (q_wr_desc),
		.q_full   (q_full),
		.rd_valid (q_valid),
		.rd_desc  (q_rd_desc),
		.rd_en    (q_pop)
	);

	// bit shifter with registered result
	dssf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_desc     (q_rd_desc),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.serial_bit (serial_bit),
		.frame_end  (frame_end),
		.item_end   (item_end)
	);

	// the last bit of a transaction always closes a frame
	`DSSF_ASSERT_IMP(a_item_end_frame, !empty && item_end, frame_end)
	// the host is stalled only while the queue has no room
	`DSSF_ASSERT_IMP(a_full_needs_queue_full, full, q_full)
	// the queue is never written while full
	`DSSF_ASSERT_IMP(a_no_push_when_full, q_full, !q_push)

endmodule

// ----- design/dssf_front.sv -----
// front end: takes host transactions and turns each into a frame list
module dssf_front
	import dssf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [7:0]  byte_value,
	input  logic [15:0] pixel_color,
	input  logic [15:0] coord_start,
	input  logic [15:0] coord_end,
	output logic        q_push,
	output desc_t       q_desc,
	input  logic        q_full
);

	logic  valid_s1;
	desc_t desc_s1;
	desc_t desc_d;
	logic  take;
	logic  op_ok;

	always_comb begin
		desc_d = '0;
		op_ok  = 1'b1;
		unique case (op)
			OP_CMD_BYTE: begin
				desc_d.frame_cnt = 3'd1;
				desc_d.frames[0] = '{1'b0, byte_value};
			end
			OP_DATA_BYTE: begin
				desc_d.frame_cnt = 3'd1;
				desc_d.frames[0] = '{1'b1, byte_value};
			end
			OP_PIXEL: begin
				desc_d.frame_cnt = 3'd2;
				desc_d.frames[0] = '{1'b1, pixel_color[15:8]};
				desc_d.frames[1] = '{1'b1, pixel_color[7:0]};
			end
			OP_COL_WIN, OP_ROW_WIN: begin
				desc_d.frame_cnt = (op == OP_ROW_WIN) ? 3'd6 : 3'd5;
				desc_d.frames[0] = '{1'b0,
					(op == OP_ROW_WIN) ? CMD_ROW_ADDR : CMD_COLUMN_ADDR};
				desc_d.frames[1] = '{1'b1, coord_start[15:8]};
				desc_d.frames[2] = '{1'b1, coord_start[7:0]};
				desc_d.frames[3] = '{1'b1, coord_end[15:8]};
				desc_d.frames[4] = '{1'b1, coord_end[7:0]};
				desc_d.frames[5] = '{1'b0, CMD_MEMORY_WRITE};
			end
			default: begin
				// unknown op: taken and dropped
				op_ok = 1'b0;
			end
		endcase
	end

	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_desc = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (q_push)
				valid_s1 <= 1'b0;
			if (take && op_ok)
				valid_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && op_ok)
			desc_s1 <= desc_d;
	end

endmodule

// ----- design/dssf_queue.sv -----
// short queue of frame lists between front and back end
module dssf_queue
	import dssf_pkg::*;
#(
	parameter int DEPTH = DSSF_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  desc_t wr_desc,
	output logic  q_full,
	output logic  rd_valid,
	output desc_t rd_desc,
	input  logic  rd_en
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full   = (cnt_q == FULL_CNT);
	assign rd_valid = (cnt_q != '0);
	assign rd_desc  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_desc;
	end

endmodule

// ----- design/dssf_serializer.sv -----
// back end: shifts frame lists out one serial bit per clock while pop is held
module dssf_serializer
	import dssf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  desc_t q_desc,
	output logic  q_pop,
	output logic  empty,
	input  logic  pop,
	output logic  serial_bit,
	output logic  frame_end,
	output logic  item_end
);

	localparam logic [3:0] LAST_BIT = 4'(FRAME_BITS - 1);

	logic       busy_q;
	desc_t      desc_q;
	logic [2:0] frame_idx_q;
	logic [3:0] bit_idx_q;
	logic       out_valid_q;
	logic       bit_q;
	logic       frame_end_q;
	logic       item_end_q;

	logic       advance;
	logic       emit;
	logic       last_bit;
	logic       last_frame;
	frame_t     cur_frame;
	logic [8:0] cur_word;
	logic [3:0] sel;

	assign advance    = !out_valid_q || pop;
	assign emit       = busy_q && advance;
	assign last_bit   = (bit_idx_q == LAST_BIT);
	assign last_frame = (frame_idx_q == desc_q.frame_cnt - 3'd1);
	assign cur_frame  = desc_q.frames[frame_idx_q];
	assign cur_word   = {cur_frame.is_data, cur_frame.value};
	assign sel        = LAST_BIT - bit_idx_q;
	// next list is picked up as the current one sends its final bit
	assign q_pop      = q_valid && (!busy_q || (emit && last_bit && last_frame));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			frame_idx_q <= '0;
			bit_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= busy_q;
			if (emit) begin
				if (last_bit) begin
					bit_idx_q   <= '0;
					frame_idx_q <= frame_idx_q + 3'd1;
					if (last_frame)
						busy_q <= 1'b0;
				end else begin
					bit_idx_q <= bit_idx_q + 4'd1;
				end
			end
			if (q_pop) begin
				busy_q      <= 1'b1;
				frame_idx_q <= '0;
				bit_idx_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			desc_q <= q_desc;
		if (emit) begin
			bit_q       <= cur_word[sel];
			frame_end_q <= last_bit;
			item_end_q  <= last_bit && last_frame;
		end
	end

	assign empty      = !out_valid_q;
	assign serial_bit = bit_q;
	assign frame_end  = frame_end_q;
	assign item_end   = item_end_q;

endmodule

// ----- sim/dssf_frame_checker.sv -----
// checker for the serial frame sender: predicts serial bits per transaction and compares
module dssf_frame_checker
	import dssf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [2:0]  op,
	input  logic [7:0]  byte_value,
	input  logic [15:0] pixel_color,
	input  logic [15:0] coord_start,
	input  logic [15:0] coord_end,
	input  logic        empty,
	input  logic        pop,
	input  logic        serial_bit,
	input  logic        frame_end,
	input  logic        item_end,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic sbit;
		logic fend;
		logic iend;
	} serial_beat_t;

	serial_beat_t expected_beats[$];
	int fail_count = 0;
	int pending_beats = 0;
	int beats_seen = 0;

	assign mismatches = fail_count;
	assign outstanding = pending_beats;

	task automatic report(input string what);
		fail_count++;
		$display("[%0t] dssf mismatch: %s", $realtime, what);
	endtask

	// frame list of one transaction, then flag bit plus byte msb first per frame
	function automatic void predict_serial_beats(input logic [2:0] opc, input logic [7:0] bv,
		input logic [15:0] px, input logic [15:0] cs, input logic [15:0] ce);
		frame_t frames[$];
		serial_beat_t beat;
		case (opc)
		OP_CMD_BYTE: frames.push_back('{1'b0, bv});
		OP_DATA_BYTE: frames.push_back('{1'b1, bv});
		OP_PIXEL: begin
			frames.push_back('{1'b1, px[15:8]});
			frames.push_back('{1'b1, px[7:0]});
		end
		OP_COL_WIN, OP_ROW_WIN: begin
			frames.push_back('{1'b0, (opc == OP_COL_WIN) ? CMD_COLUMN_ADDR : CMD_ROW_ADDR});
			frames.push_back('{1'b1, cs[15:8]});
			frames.push_back('{1'b1, cs[7:0]});
			frames.push_back('{1'b1, ce[15:8]});
			frames.push_back('{1'b1, ce[7:0]});
			if (opc == OP_ROW_WIN)
				frames.push_back('{1'b0, CMD_MEMORY_WRITE});
		end
		default: ;
		endcase
		foreach (frames[f]) begin
			for (int b = 0; b < FRAME_BITS; b++) begin
				beat.sbit = (b == 0) ? frames[f].is_data : frames[f].value[FRAME_BITS - 1 - b];
				beat.fend = (b == FRAME_BITS - 1);
				beat.iend = beat.fend && (f == frames.size() - 1);
				expected_beats.push_back(beat);
			end
		end
	endfunction

	always @(posedge clk) begin
		serial_beat_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				beats_seen++;
				if (expected_beats.size() == 0) begin
					report($sformatf("bit %0d: serial bit %b with nothing expected",
						beats_seen, serial_bit));
				end else begin
					want = expected_beats.pop_front();
					if (serial_bit !== want.sbit)
						report($sformatf("bit %0d: serial_bit %b, want %b",
							beats_seen, serial_bit, want.sbit));
					if (frame_end !== want.fend)
						report($sformatf("bit %0d: frame_end %b, want %b",
							beats_seen, frame_end, want.fend));
					if (item_end !== want.iend)
						report($sformatf("bit %0d: item_end %b, want %b",
							beats_seen, item_end, want.iend));
				end
			end
			if (push && !full)
				predict_serial_beats(op, byte_value, pixel_color, coord_start, coord_end);
			pending_beats <= expected_beats.size();
		end
	end

endmodule

// ----- sim/display_serial_frame_sender_tb.sv -----
// testbench top for the serial frame sender: stimulus, pop pacing and verdict
module display_serial_frame_sender_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dssf_pkg::*;

	// ops above the row window are taken and dropped by the block
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

	localparam int RANDOM_ITEMS = 320;
	// slowest run: every transaction a row window (54 bits) under the sparsest pop pattern
	localparam realtime RUN_LIMIT = 3_000_000ns;

	typedef enum int {POP_ALWAYS, POP_RANDOM, POP_DUTY, POP_SPARSE} pop_mode_e;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  op;
	logic [7:0]  byte_value;
	logic [15:0] pixel_color;
	logic [15:0] coord_start;
	logic [15:0] coord_end;
	logic        empty;
	logic        pop = 1'b0;
	logic        serial_bit;
	logic        frame_end;
	logic        item_end;

	int mismatches;
	int outstanding;
	int items_sent = 0;
	int burst_left = 0;

	pop_mode_e pop_mode = POP_ALWAYS;
	int mode_cycles = 0;
	int pop_phase = 0;

	display_serial_frame_sender DUT (.*);

	// scoreboard sits beside the block and only watches the host and serial bit interfaces
	dssf_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.byte_value(byte_value),
		.pixel_color(pixel_color),
		.coord_start(coord_start),
		.coord_end(coord_end),
		.empty(empty),
		.pop(pop),
		.serial_bit(serial_bit),
		.frame_end(frame_end),
		.item_end(item_end),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs or drops bits
	initial begin
		#RUN_LIMIT;
		$display("** display_serial_frame_sender: FAILED **");
		$finish;
	end

	// receiver: pop follows a pattern that changes at random intervals,
	// from always ready through random and duty-cycled pops down to the sparsest one
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (mode_cycles == 0) begin
				pop_mode <= pop_mode_e'($urandom_range(POP_ALWAYS, POP_SPARSE));
				mode_cycles <= $urandom_range(50, 400);
			end else begin
				mode_cycles <= mode_cycles - 1;
			end
			pop_phase <= pop_phase + 1;
			case (pop_mode)
			POP_ALWAYS: pop <= 1'b1;
			POP_RANDOM: pop <= 1'($urandom_range(0, 1));
			POP_DUTY: pop <= (pop_phase % 7) < 3;
			default: pop <= (pop_phase % 16) == 0;
			endcase
		end
	end

	// sender pacing: bursts of back-to-back transactions with random gaps between;
	// now and then a long burst so the front queue fills up
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			push <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
		end
	endtask

	// one transaction on the host side; push stays high if the next one follows at once
	task automatic send_command(input logic [2:0] c, input logic [7:0] bv,
		input logic [15:0] px, input logic [15:0] cs, input logic [15:0] ce);
		push <= 1'b1;
		op <= c;
		byte_value <= bv;
		pixel_color <= px;
		coord_start <= cs;
		coord_end <= ce;
		do @(posedge clk); while (full);
		if (c <= OP_ROW_WIN)
			items_sent++;
		pace_sender();
	endtask

	// sender stands still until the last expected bit has been popped
	task automatic hold_until_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	initial begin
		int pick;
		int run_len;
		arst_n = 1'b0;
		push = 1'b0;
		op = OP_CMD_BYTE;
		byte_value = '0;
		pixel_color = '0;
		coord_start = '0;
		coord_end = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, both flag values, pixel and window extremes
		send_command(OP_CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		send_command(OP_CMD_BYTE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_command(OP_DATA_BYTE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_command(OP_DATA_BYTE, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
		send_command(OP_DATA_BYTE, 8'hA5, 16'h5A5A, 16'h5A5A, 16'h5A5A);
		send_command(OP_PIXEL, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_command(OP_PIXEL, 8'h00, 16'hFFFF, 16'h0000, 16'h0000);
		send_command(OP_PIXEL, 8'h3C, 16'h00FF, 16'h1234, 16'h4321);
		send_command(OP_PIXEL, 8'hC3, 16'hFF00, 16'h4321, 16'h1234);
		send_command(OP_COL_WIN, 8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_command(OP_ROW_WIN, 8'h00, 16'h0000, 16'hFFFF, 16'h0000);
		send_command(OP_PIXEL, 8'h00, 16'hF81F, 16'h0000, 16'h0000);
		send_command(OP_COL_WIN, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		send_command(OP_ROW_WIN, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_command(OP_COL_WIN, 8'h12, 16'h3456, 16'h00EF, 16'h0100);
		send_command(OP_ROW_WIN, 8'h34, 16'h5678, 16'h0100, 16'h013F);
		// undefined ops are swallowed, between and after real transactions
		for (int c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++)
			send_command(3'(c), 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_command(OP_CMD_BYTE, 8'h2C, 16'h0000, 16'h0000, 16'h0000);
		send_command(OP_LAST_UNUSED, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		hold_until_drained();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				// the usual drawing sequence: column window, row window, pixels
				send_command(OP_COL_WIN, 8'($urandom), rand16(), rand16(), rand16());
				send_command(OP_ROW_WIN, 8'($urandom), rand16(), rand16(), rand16());
				run_len = $urandom_range(1, 12);
				repeat (run_len)
					send_command(OP_PIXEL, 8'($urandom), rand16(), rand16(), rand16());
			end else if (pick <= 7) begin
				// command followed by its parameter bytes
				send_command(OP_CMD_BYTE, 8'($urandom), rand16(), rand16(), rand16());
				run_len = $urandom_range(0, 4);
				repeat (run_len)
					send_command(OP_DATA_BYTE, 8'($urandom), rand16(), rand16(), rand16());
			end else if (pick == 8) begin
				// noise: any op, undefined ones included
				send_command(3'($urandom_range(OP_CMD_BYTE, OP_LAST_UNUSED)), 8'($urandom),
					rand16(), rand16(), rand16());
			end else begin
				// broken sequence: a lone window op, or pixels with no window set
				if ($urandom_range(0, 1) == 1)
					send_command($urandom_range(0, 1) ? OP_COL_WIN : OP_ROW_WIN, 8'($urandom),
						rand16(), rand16(), rand16());
				else
					send_command(OP_PIXEL, 8'($urandom), rand16(), rand16(), rand16());
			end
			if ($urandom_range(0, 39) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		// keep watching for any stray bit after the last expected one
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("** display_serial_frame_sender: PASSED **");
		else
			$display("** display_serial_frame_sender: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/dssf_pkg.sv
design/dssf_front.sv
design/dssf_queue.sv
design/dssf_serializer.sv
design/display_serial_frame_sender.sv
sim/dssf_frame_checker.sv
sim/display_serial_frame_sender_tb.sv
